### sv/assert_macros.svh
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/dbm_pkg.sv
// Constants for the drawdown breach monitor.
`default_nettype none

package dbm_pkg;

  localparam int RET_W    = 32;  // return, signed Q8.24
  localparam int GROW_W   = 32;  // growth factor, unsigned Q8.24
  localparam int EQ_W     = 48;  // equity and peak, unsigned Q16.32
  localparam int LIMIT_W  = 25;  // drawdown, unsigned Q1.24
  localparam int POS_W    = 32;  // reported position
  localparam int TDATA_W  = 64;  // result word, padded to whole bytes
  localparam int STEP_W   = 5;

  localparam int MUL_STEPS = 32;  // one multiplier bit per cycle
  localparam int DIV_STEPS = 25;  // one quotient bit per cycle

  localparam logic [EQ_W-1:0]    ONE_Q32     = 48'h0001_0000_0000;
  localparam logic [EQ_W-1:0]    EQ_MAX      = 48'hFFFF_FFFF_FFFF;
  localparam logic [LIMIT_W-1:0] ONE_Q24     = 25'h100_0000;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 25'd3355443;

endpackage

`default_nettype wire

### sv/drawdown_breach_monitor_top.sv
// Maximum-drawdown tracker with latched breach, serial multiply and divide.
// Sequence: once a word is accepted, a bit-serial equity multiply, an update
// step, a restoring divide and a finish step; a word arriving after a breach
// goes straight to the finish step. A new word is accepted only in idle, once
// the previous result is registered; the finish step waits for a free output.
// Reset (rst, synchronous): equity and peak 1.0, drawdown, count and breach 0,
// limit 3355443, output empty.
`default_nettype none

module drawdown_breach_monitor_top #(
  parameter int COUNT_BITS = 32
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire  [dbm_pkg::RET_W-1:0]    s_axis_tdata,   // [31:0] daily_return
  input  wire  [0:0]                   s_axis_tuser,   // [0] series_start
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  output logic [dbm_pkg::TDATA_W-1:0]  m_axis_tdata,   // [31:0] position_index,
                                                       // [56:32] max_drawdown
  output logic [0:0]                   m_axis_tuser,   // [0] breached
  input  wire                          cfg_we,
  input  wire  [dbm_pkg::LIMIT_W-1:0]  cfg_wdata       // drawdown_limit
);

  import dbm_pkg::*;

  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_EQ,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t                 state;
  logic [STEP_W-1:0]      step;
  logic                   skip;

  // series state
  logic [EQ_W-1:0]        equity;
  logic [EQ_W-1:0]        peak;
  logic [LIMIT_W-1:0]     worst;
  logic [COUNT_BITS-1:0]  item_count;
  logic                   breach_latched;
  logic [COUNT_BITS-1:0]  breach_pos;
  logic [LIMIT_W-1:0]     limit;

  // serial datapath
  logic [EQ_W-1:0]        mcand;
  logic [EQ_W-1:0]        prod_hi;
  logic [GROW_W-1:0]      mplier;
  logic [EQ_W:0]          rem;
  logic [LIMIT_W-1:0]     quot;

  // growth factor 1 + r, clamped at zero
  logic signed [RET_W:0]  grow_sum;
  logic [GROW_W-1:0]      grow;

  always_comb begin
    grow_sum = $signed({8'd0, ONE_Q24}) +
               $signed({s_axis_tdata[RET_W-1], s_axis_tdata});
    grow     = grow_sum[RET_W] ? '0 : grow_sum[GROW_W-1:0];
  end

  // multiplier step: add multiplicand on a set bit, shift right
  logic [EQ_W:0] mul_sum;
  assign mul_sum = {1'b0, prod_hi} + (mplier[0] ? {1'b0, mcand} : '0);

  // equity after scaling: product >> 24, saturated to 48 bits
  logic [EQ_W-1:0] eq_new;
  logic [EQ_W-1:0] peak_new;
  always_comb begin
    eq_new   = (|prod_hi[EQ_W-1:EQ_W-8]) ? EQ_MAX : {prod_hi[EQ_W-9:0], mplier[GROW_W-1:24]};
    peak_new = (eq_new > peak) ? eq_new : peak;
  end

  // divider step: compare, subtract, shift
  logic          div_ge;
  logic [EQ_W:0] div_diff;
  logic [EQ_W-1:0] div_rem;
  always_comb begin
    div_diff = rem - {1'b0, peak};
    div_ge   = (rem >= {1'b0, peak});
    div_rem  = div_ge ? div_diff[EQ_W-1:0] : rem[EQ_W-1:0];
  end

  // finish: drawdown, breach test, count
  logic [LIMIT_W-1:0]    dd;
  logic [LIMIT_W-1:0]    worst_next;
  logic                  hit;
  logic                  breach_next;
  logic [COUNT_BITS-1:0] breach_pos_next;
  logic [COUNT_BITS-1:0] count_next;
  logic [63:0]           pos_ext;
  logic                  out_free;

  always_comb begin
    dd              = (quot > ONE_Q24) ? ONE_Q24 : quot;
    worst_next      = (!skip && dd > worst) ? dd : worst;
    hit             = !skip && (worst_next >= limit);
    breach_next     = breach_latched || hit;
    breach_pos_next = hit ? item_count : breach_pos;
    count_next      = (skip || (&item_count)) ? item_count : item_count + 1'b1;
    pos_ext         = 64'(breach_next ? breach_pos_next : count_next);
    out_free        = !m_axis_tvalid || m_axis_tready;
  end

  assign s_axis_tready = (state == ST_IDLE);

  // control, series state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      step           <= '0;
      skip           <= 1'b0;
      equity         <= ONE_Q32;
      peak           <= ONE_Q32;
      worst          <= '0;
      item_count     <= '0;
      breach_latched <= 1'b0;
      breach_pos     <= '0;
      limit          <= LIMIT_RESET;
      m_axis_tvalid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit <= cfg_wdata;
      end
      // result valid: load on finish, drop once taken
      if (state == ST_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            if (s_axis_tuser[0]) begin
              equity         <= ONE_Q32;
              peak           <= ONE_Q32;
              worst          <= '0;
              item_count     <= '0;
              breach_latched <= 1'b0;
              breach_pos     <= '0;
            end
            mcand   <= s_axis_tuser[0] ? ONE_Q32 : equity;
            prod_hi <= '0;
            mplier  <= grow;
            step    <= '0;
            skip    <= breach_latched && !s_axis_tuser[0];
            state   <= (breach_latched && !s_axis_tuser[0]) ? ST_DONE : ST_MUL;
          end
        end
        ST_MUL: begin
          prod_hi <= mul_sum[EQ_W:1];
          mplier  <= {mul_sum[0], mplier[GROW_W-1:1]};
          step    <= step + 1'b1;
          if (step == STEP_W'(MUL_STEPS - 1)) begin
            state <= ST_EQ;
          end
        end
        ST_EQ: begin
          equity <= eq_new;
          peak   <= peak_new;
          rem    <= {1'b0, peak_new - eq_new};
          quot   <= '0;
          step   <= '0;
          state  <= ST_DIV;
        end
        ST_DIV: begin
          rem  <= {div_rem, 1'b0};
          quot <= {quot[LIMIT_W-2:0], div_ge};
          step <= step + 1'b1;
          if (step == STEP_W'(DIV_STEPS - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            worst          <= worst_next;
            breach_latched <= breach_next;
            breach_pos     <= breach_pos_next;
            item_count     <= count_next;
            m_axis_tuser   <= breach_next;
            m_axis_tdata   <= {7'd0, worst_next, pos_ext[POS_W-1:0]};
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // checks on the datapath and sequencing
  `ASSERT_CLK(a_peak_ge_equity, peak >= equity, "peak below equity")
  `ASSERT_CLK(a_peak_floor, |peak[EQ_W-1:32], "peak below 1.0")
  `ASSERT_CLK(a_worst_range, worst <= ONE_Q24, "drawdown above 1.0")
  `ASSERT_CLK(a_result_load, (state == ST_DONE && out_free) |=> m_axis_tvalid, "result lost")
  `ASSERT_CLK(a_div_steps, (state == ST_DIV) |-> (step < STEP_W'(DIV_STEPS)), "divider overrun")

endmodule

`default_nettype wire
